/* src/ectt_pkg.sv */
// Shared types and constants for the event coalescing throttle table.
// Used by ectt_entry_unit, ectt_seq and event_coalescing_throttle_table_core.
`default_nettype none

package ectt_pkg;

  // Table sizes and key width
  localparam int ACTIVE_DEPTH  = 16;
  localparam int WAITING_DEPTH = 16;
  localparam int KEY_BITS      = 32;

  // Widths of the external fields
  localparam int KEY_FIELD_W = 32;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;

  // Keys are held at the narrower of the table key width and the port width
  localparam int KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

  // Table index and occupancy widths
  localparam int MAX_DEPTH = (ACTIVE_DEPTH > WAITING_DEPTH) ? ACTIVE_DEPTH : WAITING_DEPTH;
  localparam int AIDX_W    = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
  localparam int WIDX_W    = (WAITING_DEPTH > 1) ? $clog2(WAITING_DEPTH) : 1;
  localparam int AUSED_W   = $clog2(ACTIVE_DEPTH + 1);
  localparam int WUSED_W   = $clog2(WAITING_DEPTH + 1);
  localparam int WALK_W    = $clog2(MAX_DEPTH + 1);

  // Command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT   = 2'd1;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 8'd5;

  // Timeout settings handed to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] active_timeout;
    logic [CNT_W-1:0] wait_timeout;
  } timeouts_t;

  // One emission pushed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             last;
  } emit_t;

endpackage : ectt_pkg

`default_nettype wire

/* src/event_coalescing_throttle_table_core.sv */
// Top level of the event coalescing throttle table: channels, timeout
// registers and the output register. Depends on ectt_pkg and ectt_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   in      | input     | in_valid / in_stall  | command, key
//   out     | output    | out_valid / out_stall| emitted_key, last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item keeps the block busy until its walk ends: an event searches active,
// then waiting, closing the gap it leaves; a tick counts down active, then
// waiting. One compare/countdown unit serves both walks, one entry per cycle
// while the output accepts; the next item transfers once the block is idle.
// rst is synchronous; both tables read as empty and both timeouts read 5.
// A stalled output holds its result and pauses the walk at the next result.
`default_nettype none

module event_coalescing_throttle_table_core
  import ectt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   command,
  input  wire logic [KEY_FIELD_W-1:0] key,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [KEY_FIELD_W-1:0]      emitted_key,
  output logic                        last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CNT_W-1:0]       cfg_data
);

  timeouts_t timeouts;
  emit_t     emit;
  logic      busy;
  logic      emit_ready;
  logic      in_xfer;

  assign cfg_ready  = 1'b1;
  assign in_stall   = busy;
  assign in_xfer    = in_valid && !in_stall;
  assign emit_ready = !out_valid || !out_stall;

  // Store timeout registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      timeouts.active_timeout <= TIMEOUT_RESET;
      timeouts.wait_timeout   <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_TIMEOUT: timeouts.active_timeout <= cfg_data;
        CFG_WAIT_TIMEOUT:   timeouts.wait_timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

  ectt_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (in_xfer),
    .start_command (command),
    .start_key     (key[KEY_W-1:0]),
    .timeouts      (timeouts),
    .emit_ready    (emit_ready),
    .busy          (busy),
    .emit          (emit)
  );

  // Output register: load a pushed result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      emitted_key <= KEY_FIELD_W'(emit.key);
      last        <= emit.last;
    end
  end

  // The sequencer pushes only into a free output slot
  assert property (@(posedge clk) disable iff (rst) emit.valid |-> emit_ready)
    else $error("result pushed while output register is occupied");

  // An idle block has no result left to push
  assert property (@(posedge clk) disable iff (rst) !in_stall |-> !emit.valid)
    else $error("result pushed while idle");

  // A new result appears only after a push
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(emit.valid))
    else $error("output became valid without a push");

  // An accepted item always makes the block busy in the cycle after
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> in_stall)
    else $error("block not busy after accepting an item");

endmodule : event_coalescing_throttle_table_core

`default_nettype wire

/* src/ectt_entry_unit.sv */
// Shared compare and countdown unit applied to one table entry per cycle.
// Depends on ectt_pkg for key and count widths.
`default_nettype none

module ectt_entry_unit
  import ectt_pkg::*;
(
  input  wire logic [KEY_W-1:0] probe_key,
  input  wire logic [KEY_W-1:0] entry_key,
  input  wire logic [CNT_W-1:0] entry_count,
  output logic                  hit,
  output logic                  expire,
  output logic [CNT_W-1:0]      dec_count
);

  // Match the probe, test for expiry (count of zero or one), count down
  always_comb begin
    hit       = (probe_key == entry_key);
    expire    = (entry_count <= CNT_W'(1));
    dec_count = entry_count - CNT_W'(1);
  end

endmodule : ectt_entry_unit

`default_nettype wire

/* src/ectt_seq.sv */
// Sequencer and table storage: walks the active and waiting tables one
// entry per cycle through the shared ectt_entry_unit. Depends on ectt_pkg.
`default_nettype none

module ectt_seq
  import ectt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             start_command,
  input  wire logic [KEY_W-1:0] start_key,
  input  wire timeouts_t        timeouts,
  input  wire logic             emit_ready,
  output logic                  busy,
  output emit_t                 emit
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASRCH,
    S_WSRCH,
    S_SHIFT,
    S_MOVE,
    S_TACT,
    S_TWAIT
  } state_t;

  // Control registers
  state_t               state, state_next;
  logic [KEY_W-1:0]     cur_key, cur_key_next;
  logic [WALK_W-1:0]    idx, idx_next;
  logic [WALK_W-1:0]    wr, wr_next;
  logic [AUSED_W-1:0]   a_used, a_used_next;
  logic [WUSED_W-1:0]   w_used, w_used_next;
  logic [WIDX_W-1:0]    w_head, w_head_next;
  logic                 pend_valid, pend_valid_next;
  logic [KEY_W-1:0]     pend_key, pend_key_next;

  // Table storage; active is linear, waiting is a ring starting at w_head
  logic [KEY_W-1:0]     a_key [ACTIVE_DEPTH];
  logic [CNT_W-1:0]     a_cnt [ACTIVE_DEPTH];
  logic [KEY_W-1:0]     w_key [WAITING_DEPTH];
  logic [CNT_W-1:0]     w_cnt [WAITING_DEPTH];

  // Write ports
  logic                 a_we;
  logic [AIDX_W-1:0]    a_wa;
  logic [KEY_W-1:0]     a_wkey;
  logic [CNT_W-1:0]     a_wcnt;
  logic                 w_we;
  logic [WIDX_W-1:0]    w_wa;
  logic [KEY_W-1:0]     w_wkey;
  logic [CNT_W-1:0]     w_wcnt;

  // Read side and shared unit
  logic [KEY_W-1:0]     a_rkey;
  logic [CNT_W-1:0]     a_rcnt;
  logic [WIDX_W-1:0]    w_ra;
  logic [KEY_W-1:0]     w_rkey;
  logic [CNT_W-1:0]     w_rcnt;
  logic                 use_active;
  logic [KEY_W-1:0]     u_key;
  logic [CNT_W-1:0]     u_cnt;
  logic                 u_hit;
  logic                 u_expire;
  logic [CNT_W-1:0]     u_dec;

  // Waiting append request
  logic                 w_app;
  logic [KEY_W-1:0]     w_app_key;

  logic [WALK_W-1:0]    idx_inc;
  logic                 a_end;
  logic                 w_end;
  logic                 a_full;
  logic                 w_full;

  // Map a logical waiting position onto the ring
  function automatic logic [WIDX_W-1:0] wphys(input logic [WIDX_W-1:0] head,
                                              input logic [WALK_W-1:0] pos);
    logic [WALK_W:0] sum;
    sum = (WALK_W+1)'(head) + (WALK_W+1)'(pos);
    if (sum >= (WALK_W+1)'(WAITING_DEPTH)) begin
      sum = sum - (WALK_W+1)'(WAITING_DEPTH);
    end
    return sum[WIDX_W-1:0];
  endfunction

  function automatic logic [WIDX_W-1:0] whead_inc(input logic [WIDX_W-1:0] head);
    logic [WIDX_W-1:0] res;
    if (head == WIDX_W'(WAITING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = head + WIDX_W'(1);
    end
    return res;
  endfunction

  // Read one entry of each table
  always_comb begin
    w_ra   = wphys(w_head, idx);
    a_rkey = a_key[idx[AIDX_W-1:0]];
    a_rcnt = a_cnt[idx[AIDX_W-1:0]];
    w_rkey = w_key[w_ra];
    w_rcnt = w_cnt[w_ra];
    use_active = (state == S_ASRCH) || (state == S_TACT);
    u_key  = use_active ? a_rkey : w_rkey;
    u_cnt  = use_active ? a_rcnt : w_rcnt;
  end

  ectt_entry_unit u_entry (
    .probe_key   (cur_key),
    .entry_key   (u_key),
    .entry_count (u_cnt),
    .hit         (u_hit),
    .expire      (u_expire),
    .dec_count   (u_dec)
  );

  // Sequencer next-state logic
  always_comb begin
    state_next      = state;
    cur_key_next    = cur_key;
    idx_next        = idx;
    wr_next         = wr;
    a_used_next     = a_used;
    w_used_next     = w_used;
    w_head_next     = w_head;
    pend_valid_next = pend_valid;
    pend_key_next   = pend_key;
    a_we            = 1'b0;
    a_wa            = idx[AIDX_W-1:0];
    a_wkey          = a_rkey;
    a_wcnt          = timeouts.active_timeout;
    w_we            = 1'b0;
    w_wa            = wphys(w_head, wr);
    w_wkey          = w_rkey;
    w_wcnt          = u_dec;
    w_app           = 1'b0;
    w_app_key       = cur_key;
    emit            = '0;

    idx_inc = idx + WALK_W'(1);
    a_end   = (idx == WALK_W'(a_used));
    w_end   = (idx == WALK_W'(w_used));
    a_full  = (a_used == AUSED_W'(ACTIVE_DEPTH));
    w_full  = (w_used == WUSED_W'(WAITING_DEPTH));

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_key_next = start_key;
          idx_next     = '0;
          wr_next      = '0;
          state_next   = (start_command == CMD_TICK) ? S_TACT : S_ASRCH;
        end
      end

      // Look for the key among active entries; restart its countdown on a hit
      S_ASRCH: begin
        if (a_end) begin
          idx_next   = '0;
          state_next = S_WSRCH;
        end else if (u_hit) begin
          a_we       = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end

      // Look for the key among waiting entries; report it at once if absent
      S_WSRCH: begin
        if (w_end) begin
          if (emit_ready) begin
            emit       = '{valid: 1'b1, key: cur_key, last: 1'b1};
            w_app      = 1'b1;
            state_next = S_IDLE;
          end
        end else if (u_hit) begin
          if (idx_inc == WALK_W'(w_used)) begin
            w_used_next = w_used - WUSED_W'(1);
            state_next  = S_MOVE;
          end else begin
            wr_next    = idx;
            idx_next   = idx_inc;
            state_next = S_SHIFT;
          end
        end else begin
          idx_next = idx_inc;
        end
      end

      // Close the gap left by the removed waiting entry
      S_SHIFT: begin
        w_we     = 1'b1;
        w_wcnt   = w_rcnt;
        wr_next  = wr + WALK_W'(1);
        idx_next = idx_inc;
        if (idx_inc == WALK_W'(w_used)) begin
          w_used_next = w_used - WUSED_W'(1);
          state_next  = S_MOVE;
        end
      end

      // Append to the active table, or report at once when it is full
      S_MOVE: begin
        if (!a_full) begin
          a_we        = 1'b1;
          a_wa        = a_used[AIDX_W-1:0];
          a_wkey      = cur_key;
          a_used_next = a_used + AUSED_W'(1);
          state_next  = S_IDLE;
        end else if (emit_ready) begin
          emit       = '{valid: 1'b1, key: cur_key, last: 1'b1};
          w_app      = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Tick over active entries: hold each expiry until the next one shows
      // whether it is the final report
      S_TACT: begin
        if (a_end) begin
          if (!pend_valid || emit_ready) begin
            if (pend_valid) begin
              emit = '{valid: 1'b1, key: pend_key, last: 1'b1};
            end
            pend_valid_next = 1'b0;
            a_used_next     = AUSED_W'(wr);
            idx_next        = '0;
            wr_next         = '0;
            state_next      = S_TWAIT;
          end
        end else if (u_expire) begin
          if (!pend_valid || emit_ready) begin
            if (pend_valid) begin
              emit = '{valid: 1'b1, key: pend_key, last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_key_next   = a_rkey;
            w_app           = 1'b1;
            w_app_key       = a_rkey;
            idx_next        = idx_inc;
          end
        end else begin
          a_we     = 1'b1;
          a_wa     = wr[AIDX_W-1:0];
          a_wcnt   = u_dec;
          wr_next  = wr + WALK_W'(1);
          idx_next = idx_inc;
        end
      end

      // Tick over waiting entries: count down and drop expired ones
      S_TWAIT: begin
        if (w_end) begin
          w_used_next = WUSED_W'(wr);
          state_next  = S_IDLE;
        end else begin
          if (!u_expire) begin
            w_we    = 1'b1;
            wr_next = wr + WALK_W'(1);
          end
          idx_next = idx_inc;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Append to the waiting table, evicting the oldest entry when full
    if (w_app) begin
      w_we   = 1'b1;
      w_wkey = w_app_key;
      w_wcnt = timeouts.wait_timeout;
      if (w_full) begin
        w_wa        = w_head;
        w_head_next = whead_inc(w_head);
      end else begin
        w_wa        = wphys(w_head, WALK_W'(w_used));
        w_used_next = w_used + WUSED_W'(1);
      end
    end
  end

  assign busy = (state != S_IDLE);

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      a_used     <= '0;
      w_used     <= '0;
      w_head     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      a_used     <= a_used_next;
      w_used     <= w_used_next;
      w_head     <= w_head_next;
      pend_valid <= pend_valid_next;
    end
    cur_key  <= cur_key_next;
    idx      <= idx_next;
    wr       <= wr_next;
    pend_key <= pend_key_next;
  end

  // Write table entries
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_key[a_wa] <= a_wkey;
      a_cnt[a_wa] <= a_wcnt;
    end
    if (w_we) begin
      w_key[w_wa] <= w_wkey;
      w_cnt[w_wa] <= w_wcnt;
    end
  end

endmodule : ectt_seq

`default_nettype wire
